// ===== sv/ptb_pkg.sv =====
`default_nettype none

package ptb_pkg;

  // Fixed field widths of the command channel.
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 3;
  localparam int VALUE_W = 16;

  // Command codes; code 7 is unused and does nothing.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 3'd0,
    CMD_START        = 3'd1,
    CMD_TEST_FLAG    = 3'd2,
    CMD_CLEAR_FLAG   = 3'd3,
    CMD_STOP         = 3'd4,
    CMD_LOAD_TIMEOUT = 3'd5,
    CMD_TEST_TIMEOUT = 3'd6
  } cmd_t;

  // Command token that walks down the cell chain and gathers the answer.
  typedef struct packed {
    logic                 valid;
    cmd_t                 cmd;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
    logic                 flag;
  } token_t;

endpackage

`default_nettype wire

// ===== sv/ptb_cell.sv =====
`default_nettype none

module ptb_cell #(
  parameter int  CELL_ID     = 0,
  parameter bit  HAS_P       = 1'b1,
  parameter bit  HAS_T       = 1'b1,
  parameter int  COUNT_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire ptb_pkg::token_t tok_in,
  output ptb_pkg::token_t      tok_out
);
  import ptb_pkg::*;

  localparam bit REACH = (CELL_ID < (1 << INDEX_W));

  logic [COUNT_WIDTH-1:0] pcount;
  logic [COUNT_WIDTH-1:0] preload;
  logic                   pactive;
  logic                   pdone;
  logic [COUNT_WIDTH-1:0] tcount;

  logic                   hit;
  logic                   pmatch;
  logic                   tmatch;
  logic                   work;
  logic [COUNT_WIDTH-1:0] val;
  logic [COUNT_WIDTH-1:0] pdec;
  logic                   answer;

  // Decode whether this cell takes part in the passing command.
  always_comb begin
    hit    = REACH && (tok_in.index == INDEX_W'(CELL_ID));
    pmatch = HAS_P && hit;
    tmatch = HAS_T && hit;
    work   = advance && tok_in.valid;
    val    = COUNT_WIDTH'(tok_in.value);
    pdec   = pcount - COUNT_WIDTH'(1);
  end

  // Answer of the test commands addressed to this cell.
  always_comb begin
    answer = 1'b0;
    case (tok_in.cmd)
      CMD_TEST_FLAG:    answer = pmatch && pdone;
      CMD_TEST_TIMEOUT: answer = tmatch && (tcount == '0);
      default:          answer = 1'b0;
    endcase
  end

  // Counter state of this entry, updated as the token passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount  <= '0;
      preload <= '0;
      pactive <= 1'b0;
      pdone   <= 1'b0;
      tcount  <= '0;
    end else if (work) begin
      case (tok_in.cmd)
        CMD_TICK: begin
          if (HAS_P && pactive) begin
            if (pdec == '0) begin
              pcount <= preload;
              pdone  <= 1'b1;
            end else begin
              pcount <= pdec;
            end
          end
          if (HAS_T && (tcount != '0)) begin
            tcount <= tcount - COUNT_WIDTH'(1);
          end
        end
        CMD_START: begin
          if (pmatch) begin
            pactive <= 1'b1;
            pdone   <= 1'b0;
            preload <= val;
            pcount  <= val;
          end
        end
        CMD_CLEAR_FLAG: begin
          if (pmatch) begin
            pdone <= 1'b0;
          end
        end
        CMD_STOP: begin
          if (pmatch) begin
            pactive <= 1'b0;
          end
        end
        CMD_LOAD_TIMEOUT: begin
          if (tmatch) begin
            tcount <= val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hand the token on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_out.cmd   <= tok_in.cmd;
      tok_out.index <= tok_in.index;
      tok_out.value <= tok_in.value;
      tok_out.flag  <= tok_in.flag | answer;
    end
  end

endmodule

`default_nettype wire

// ===== sv/periodic_and_timeout_timer_bank.sv =====
// A command's result is registered in the output register after its token has passed every cell.
// One command is in flight at a time: its token walks the cell chain one cell per cycle,
// output stalls hold the chain, and a new command is taken once the token leaves the last cell.
// Reset (synchronous, active high) clears all counters, periods, flags and activity bits
// and empties the chain and the output register.
`default_nettype none

module periodic_and_timeout_timer_bank #(
  parameter int NUM_PERIODIC = 8,
  parameter int NUM_TIMEOUT  = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [ptb_pkg::CMD_W-1:0]    command,
  input  wire logic [ptb_pkg::INDEX_W-1:0]  index,
  input  wire logic [ptb_pkg::VALUE_W-1:0]  value,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic                         flag
);
  import ptb_pkg::*;

  localparam int NUM_CELLS = (NUM_PERIODIC > NUM_TIMEOUT) ? NUM_PERIODIC : NUM_TIMEOUT;

  token_t               tok [NUM_CELLS+1];
  token_t               tok_head;
  logic [NUM_CELLS-1:0] tok_valid;
  logic                 busy;
  logic                 advance;
  logic                 in_xfer;
  logic                 last_valid;

  // Input transfer and the token that enters the first cell.
  always_comb begin
    in_ready       = !busy;
    in_xfer        = in_valid && in_ready;
    tok_head.valid = in_xfer;
    tok_head.cmd   = cmd_t'(command);
    tok_head.index = index;
    tok_head.value = value;
    tok_head.flag  = 1'b0;
    last_valid     = tok[NUM_CELLS].valid;
    advance        = !out_valid || out_ready || !last_valid;
  end

  assign tok[0] = tok_head;

  // Chain of counter cells, one per index, each holding that index's periodic and timeout counters where they exist.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ptb_cell #(
      .CELL_ID     (k),
      .HAS_P       (k < NUM_PERIODIC),
      .HAS_T       (k < NUM_TIMEOUT),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
    assign tok_valid[k] = tok[k+1].valid;
  end

  // One command in flight at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_xfer) begin
      busy <= 1'b1;
    end else if (advance && last_valid) begin
      busy <= 1'b0;
    end
  end

  // Output register takes the token leaving the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_valid) begin
      flag <= tok[NUM_CELLS].flag;
    end
  end

`ifndef NO_ASSERTIONS
  // At most one command token is in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_valid))
    else $error("more than one command token in the cell chain");

  // The block is busy exactly while a token is in the chain.
  a_busy_match: assert property (@(posedge clk) disable iff (rst) busy == (|tok_valid))
    else $error("busy flag disagrees with the chain contents");

  // A new result only comes from a token that left the last cell.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(last_valid))
    else $error("result appeared without a token leaving the chain");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/periodic_and_timeout_timer_bank_test.sv =====
`default_nettype none

module periodic_and_timeout_timer_bank_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptb_pkg::*;

  localparam int NUM_PERIODIC = 8;
  localparam int NUM_TIMEOUT  = 8;
  localparam int COUNT_WIDTH  = 16;
  localparam int CHAIN_CYCLES = ((NUM_PERIODIC > NUM_TIMEOUT) ? NUM_PERIODIC : NUM_TIMEOUT) + 1;

  // Code 7 has no enum member; the block must treat it as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // Block ports.
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command = '0;
  logic [INDEX_W-1:0]   index = '0;
  logic [VALUE_W-1:0]   value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 flag;

  periodic_and_timeout_timer_bank #(
    .NUM_PERIODIC(NUM_PERIODIC),
    .NUM_TIMEOUT (NUM_TIMEOUT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .index    (index),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .flag     (flag)
  );

  // Our own copy of the timer bank state.
  logic [COUNT_WIDTH-1:0] period_count  [NUM_PERIODIC];
  logic [COUNT_WIDTH-1:0] period_reload [NUM_PERIODIC];
  logic                   period_running[NUM_PERIODIC];
  logic                   period_fired  [NUM_PERIODIC];
  logic [COUNT_WIDTH-1:0] timeout_left  [NUM_TIMEOUT];

  // One awaited answer, with the command that asked for it.
  typedef struct {
    logic               answer;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
  } awaited_flag_t;

  awaited_flag_t awaited_flags[$];
  awaited_flag_t oldest_flag;

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Advance one tick over every periodic and timeout counter.
  function automatic void tick_bank();
    logic [COUNT_WIDTH-1:0] next_count;
    for (int k = 0; k < NUM_PERIODIC; k++) begin
      if (period_running[k]) begin
        next_count = period_count[k] - 1'b1;
        if (next_count == '0) begin
          period_count[k] = period_reload[k];
          period_fired[k] = 1'b1;
        end else begin
          period_count[k] = next_count;
        end
      end
    end
    for (int k = 0; k < NUM_TIMEOUT; k++) begin
      if (timeout_left[k] != '0) timeout_left[k] = timeout_left[k] - 1'b1;
    end
  endfunction

  // Apply one command to the state and return the answer it yields.
  function automatic logic apply_timer_command(input logic [CMD_W-1:0] cmd,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [VALUE_W-1:0] val);
    logic answer;
    answer = 1'b0;
    case (cmd)
      CMD_TICK: begin
        tick_bank();
      end
      CMD_START: begin
        period_running[idx] = 1'b1;
        period_fired[idx]   = 1'b0;
        period_reload[idx]  = val[COUNT_WIDTH-1:0];
        period_count[idx]   = val[COUNT_WIDTH-1:0];
      end
      CMD_TEST_FLAG: begin
        answer = period_fired[idx];
      end
      CMD_CLEAR_FLAG: begin
        period_fired[idx] = 1'b0;
      end
      CMD_STOP: begin
        period_running[idx] = 1'b0;
      end
      CMD_LOAD_TIMEOUT: begin
        timeout_left[idx] = val[COUNT_WIDTH-1:0];
      end
      CMD_TEST_TIMEOUT: begin
        answer = (timeout_left[idx] == '0);
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  // Send one command; record its answer when the transfer happens.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
    awaited_flag_t item;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    index    <= idx;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item.answer = apply_timer_command(cmd, idx, val);
    item.cmd    = cmd;
    item.idx    = idx;
    awaited_flags.push_back(item);
  endtask

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer against the oldest awaited answer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_flags.size() == 0) begin
        report_mismatch($sformatf("result flag=%0b with nothing awaited", flag));
      end else begin
        oldest_flag = awaited_flags.pop_front();
        if (flag !== oldest_flag.answer)
          report_mismatch($sformatf("command %0d index %0d: flag=%b, wanted %b",
                                    oldest_flag.cmd, oldest_flag.idx, flag,
                                    oldest_flag.answer));
      end
    end
  end

  // After reset: periodic flag 0 is clear and timeout 7 has expired; then a tick is sent.
  task automatic test_after_reset();
    send_command(CMD_TEST_FLAG, 3'd0, '0);
    send_command(CMD_TEST_TIMEOUT, 3'd7, '0);
    send_command(CMD_TICK, 3'd0, '0);
  endtask

  // Start, fire, test, clear and stop periodic counters.
  task automatic test_periodic();
    send_command(CMD_START, 3'd0, 16'd1);
    send_command(CMD_START, 3'd7, 16'd2);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TEST_FLAG, 3'd0, '0);
    send_command(CMD_STOP, 3'd0, '0);
    send_command(CMD_TEST_FLAG, 3'd0, '0);
    send_command(CMD_CLEAR_FLAG, 3'd0, '0);
    send_command(CMD_TEST_FLAG, 3'd0, '0);
    send_command(CMD_STOP, 3'd7, '0);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TEST_FLAG, 3'd7, '0);
    send_command(CMD_START, 3'd3, VALUE_MAX);
  endtask

  // A zero period wraps to all ones on the first tick rather than firing.
  task automatic test_zero_period();
    send_command(CMD_START, 3'd5, '0);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TEST_FLAG, 3'd5, '0);
  endtask

  // Load timeouts, count them down and check expiry.
  task automatic test_timeouts();
    send_command(CMD_LOAD_TIMEOUT, 3'd2, 16'd2);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TEST_TIMEOUT, 3'd2, '0);
    send_command(CMD_TICK, 3'd0, '0);
    send_command(CMD_TEST_TIMEOUT, 3'd2, '0);
    send_command(CMD_LOAD_TIMEOUT, 3'd7, VALUE_MAX);
    send_command(CMD_TEST_TIMEOUT, 3'd7, '0);
  endtask

  // The unused command code must leave the bank alone.
  task automatic test_unused_command();
    send_command(CMD_UNUSED, 3'd7, VALUE_MAX);
    send_command(CMD_TEST_TIMEOUT, 3'd7, '0);
  endtask

  // Random traffic: ticks are the most frequent command and most values are small, so counters fire often.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    int                 pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35)      cmd = CMD_TICK;
      else if (pick < 47) cmd = CMD_START;
      else if (pick < 62) cmd = CMD_TEST_FLAG;
      else if (pick < 70) cmd = CMD_CLEAR_FLAG;
      else if (pick < 76) cmd = CMD_STOP;
      else if (pick < 86) cmd = CMD_LOAD_TIMEOUT;
      else if (pick < 98) cmd = CMD_TEST_TIMEOUT;
      else                cmd = CMD_UNUSED;
      pick = $urandom_range(99);
      if (pick < 10)      val = '0;
      else if (pick < 85) val = VALUE_W'($urandom_range(6, 1));
      else                val = VALUE_W'($urandom);
      send_command(cmd, INDEX_W'($urandom_range(NUM_PERIODIC - 1)), val);
    end
  endtask

  // Main sequence.
  initial begin
    for (int k = 0; k < NUM_PERIODIC; k++) begin
      period_count[k]   = '0;
      period_reload[k]  = '0;
      period_running[k] = 1'b0;
      period_fired[k]   = 1'b0;
    end
    for (int k = 0; k < NUM_TIMEOUT; k++) timeout_left[k] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_periodic();
    test_zero_period();
    test_timeouts();
    test_unused_command();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 54, 0);
    test_random_traffic(250, 0, 54);
    test_random_traffic(250, 26, 26);
    in_valid <= 1'b0;

    while (awaited_flags.size() != 0) @(posedge clk);
    repeat (2 * CHAIN_CYCLES + 4) @(posedge clk);

    if (mismatch_count == 0 && awaited_flags.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
